>>> src/tmcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcl_pkg
// shared types, constants and helpers of the tile mean color and luma block
// ----------------------------------------------------------------------------
package tmcl_pkg;

	localparam int DEF_MAX_TILES  = 256;
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int CFG_W    = 13;              // register and pixel coordinate width
	localparam int SUM_W    = 34;              // color sum over up to 2^26 pixels
	localparam int LUMA_W   = 50;              // luma sum
	localparam int PLUMA_W  = 24;              // luma of one pixel
	localparam int CNT_W    = 2 * CFG_W;       // pixels in one tile
	localparam int RAM_W    = 3 * SUM_W + LUMA_W;
	localparam int MEAN_W   = 16;

	localparam logic [15:0] LUMA_WR = 16'd13933;
	localparam logic [15:0] LUMA_WG = 16'd46871;
	localparam logic [15:0] LUMA_WB = 16'd4732;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_TILE_WIDTH   = 2'd2,
		REG_TILE_HEIGHT  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
		logic [CFG_W-1:0] tile_width;
		logic [CFG_W-1:0] tile_height;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0]        tile_row;
		logic [7:0]        tile_col;
		logic [MEAN_W-1:0] mean_red;
		logic [MEAN_W-1:0] mean_green;
		logic [MEAN_W-1:0] mean_blue;
		logic [MEAN_W-1:0] mean_luma;
		logic              last_tile;
	} tile_t;

	// finished tile handed from front to back
	typedef struct packed {
		logic [7:0]        tile_row;
		logic [7:0]        tile_col;
		logic              last_tile;
		logic [SUM_W-1:0]  sum_red;
		logic [SUM_W-1:0]  sum_green;
		logic [SUM_W-1:0]  sum_blue;
		logic [LUMA_W-1:0] sum_luma;
		logic [CFG_W-1:0]  tile_w;
		logic [CFG_W-1:0]  tile_h;
	} tile_rec_t;

	typedef struct packed {
		logic      full;
		logic      empty;
	} queue_stat_t;

	typedef enum logic [2:0] {
		F_GEO_TX,
		F_GEO_TY,
		F_GEO_QX,
		F_GEO_QY,
		F_IDLE,
		F_READ,
		F_UPD
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_PREP,
		B_DIV,
		B_DONE
	} back_state_t;

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int hi);
		logic [CFG_W-1:0] res;
		res = v;
		if (v == '0)
			res = CFG_W'(1);
		else if (int'(v) > hi)
			res = CFG_W'(hi);
		return res;
	endfunction

endpackage
`default_nettype wire

>>> src/tmcl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcl_ram
// generic single write, single read port ram with registered read
// ----------------------------------------------------------------------------
module tmcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic [WIDTH-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output      logic [WIDTH-1:0]             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> src/tmcl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcl_div
// radix-2 restoring divider for geometry setup, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tmcl_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tmcl_pkg::CFG_W-1:0]  dividend,
	input  wire logic [tmcl_pkg::CFG_W-1:0]  divisor,
	output      logic                        done,
	output      logic [tmcl_pkg::CFG_W-1:0]  quot,
	output      logic [tmcl_pkg::CFG_W-1:0]  rem
);

	localparam int W   = tmcl_pkg::CFG_W;
	localparam int CW  = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [W:0]    trial;
	logic          fit;

	assign trial = {rem_q, quo_q[W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fit};
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

>>> src/tmcl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcl_queue
// two entry queue of finished tiles between front and back
// ----------------------------------------------------------------------------
module tmcl_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire tmcl_pkg::tile_rec_t    rec_in,
	input  wire logic                   pop,
	output      tmcl_pkg::tile_rec_t    rec_out,
	output      tmcl_pkg::queue_stat_t  stat
);

	tmcl_pkg::tile_rec_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rec_out    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= !wp_q;
			if (do_pop)
				rp_q <= !rp_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= rec_in;
	end

endmodule
`default_nettype wire

>>> src/tmcl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcl_front
// tile grid setup, pixel counting and per-column accumulation
// ----------------------------------------------------------------------------
module tmcl_front #(
	parameter int MAX_TILES  = tmcl_pkg::DEF_MAX_TILES,
	parameter int MAX_WIDTH  = tmcl_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tmcl_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tmcl_pkg::cfg_t         cfg,
	output      logic                   cfg_ok,
	input  wire logic                   pixel_valid,
	output      logic                   pixel_ready,
	input  wire tmcl_pkg::pixel_t       pixel,
	output      logic                   push,
	output      tmcl_pkg::tile_rec_t    rec,
	input  wire tmcl_pkg::queue_stat_t  qstat
);

	localparam int W     = tmcl_pkg::CFG_W;
	localparam int TC_W  = $clog2(MAX_TILES + 1);
	localparam int COL_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int SW    = tmcl_pkg::SUM_W;
	localparam int LW    = tmcl_pkg::LUMA_W;

	tmcl_pkg::front_state_t state_q, state_d;

	logic             issued_q, pend_q;
	tmcl_pkg::pixel_t pix_q;
	logic [tmcl_pkg::PLUMA_W-1:0] luma_q;
	logic [W-1:0]     px_q, py_q, left_q, top_q;
	logic [W-1:0]     col_edge_q, col_rem_q, row_edge_q, row_rem_q;
	logic [W-1:0]     qx_q, rx_q, qy_q, ry_q;
	logic [TC_W-1:0]  col_q, row_q, tiles_x_q, tiles_y_q;

	logic             div_start, div_done;
	logic [W-1:0]     div_a, div_b, div_q, div_r;
	logic [W-1:0]     frame_w, frame_h;
	logic [TC_W-1:0]  tcount;

	logic [tmcl_pkg::RAM_W-1:0] rd_data, wr_data;
	logic [SW-1:0]    s_r, s_g, s_b;
	logic [LW-1:0]    s_l;
	logic             first, col_end, row_end, tile_done, upd_go, ram_we;
	logic [W:0]       crem_sum, rrem_sum;

	assign frame_w = tmcl_pkg::clamp_size(cfg.image_width, MAX_WIDTH);
	assign frame_h = tmcl_pkg::clamp_size(cfg.image_height, MAX_HEIGHT);

	always_comb begin
		div_a = frame_h;
		div_b = W'(tiles_y_q);
		unique case (state_q)
			tmcl_pkg::F_GEO_TX: begin
				div_a = frame_w;
				div_b = (cfg.tile_width == '0) ? W'(1) : cfg.tile_width;
			end
			tmcl_pkg::F_GEO_TY: begin
				div_b = (cfg.tile_height == '0) ? W'(1) : cfg.tile_height;
			end
			tmcl_pkg::F_GEO_QX: begin
				div_a = frame_w;
				div_b = W'(tiles_x_q);
			end
			default: ;
		endcase
	end

	// tile count clamped to 1..MAX_TILES
	always_comb begin
		if (div_q == '0)
			tcount = TC_W'(1);
		else if (int'(div_q) > MAX_TILES)
			tcount = TC_W'(MAX_TILES);
		else
			tcount = TC_W'(div_q);
	end

	assign div_start = !issued_q && (state_q == tmcl_pkg::F_GEO_TX || state_q == tmcl_pkg::F_GEO_TY
		|| state_q == tmcl_pkg::F_GEO_QX || state_q == tmcl_pkg::F_GEO_QY);

	tmcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	tmcl_ram #(
		.WIDTH (tmcl_pkg::RAM_W),
		.DEPTH (MAX_TILES)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q[COL_W-1:0]),
		.wdata (wr_data),
		.raddr (col_q[COL_W-1:0]),
		.rdata (rd_data)
	);

	// accumulate
	assign first = (py_q == top_q) && (px_q == left_q);
	always_comb begin
		s_r = SW'(pix_q.red);
		s_g = SW'(pix_q.green);
		s_b = SW'(pix_q.blue);
		s_l = LW'(luma_q);
		if (!first) begin
			s_r = s_r + rd_data[tmcl_pkg::RAM_W-1 -: SW];
			s_g = s_g + rd_data[tmcl_pkg::RAM_W-SW-1 -: SW];
			s_b = s_b + rd_data[LW +: SW];
			s_l = s_l + rd_data[LW-1:0];
		end
	end
	assign wr_data = {s_r, s_g, s_b, s_l};

	assign col_end   = (px_q + W'(1)) == col_edge_q;
	assign row_end   = (py_q + W'(1)) == row_edge_q;
	assign tile_done = col_end && row_end;
	assign upd_go    = (state_q == tmcl_pkg::F_UPD) && !(tile_done && qstat.full);
	assign ram_we    = upd_go;
	assign push      = upd_go && tile_done;

	assign rec.tile_row  = 8'(row_q);
	assign rec.tile_col  = 8'(col_q);
	assign rec.last_tile = ((row_q + TC_W'(1)) == tiles_y_q) && ((col_q + TC_W'(1)) == tiles_x_q);
	assign rec.sum_red   = s_r;
	assign rec.sum_green = s_g;
	assign rec.sum_blue  = s_b;
	assign rec.sum_luma  = s_l;
	assign rec.tile_w    = col_edge_q - left_q;
	assign rec.tile_h    = row_edge_q - top_q;

	assign crem_sum = {1'b0, col_rem_q} + {1'b0, rx_q};
	assign rrem_sum = {1'b0, row_rem_q} + {1'b0, ry_q};

	assign pixel_ready = state_q == tmcl_pkg::F_IDLE;
	assign cfg_ok      = state_q == tmcl_pkg::F_IDLE || state_q == tmcl_pkg::F_READ
		|| state_q == tmcl_pkg::F_UPD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tmcl_pkg::F_GEO_TX;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmcl_pkg::F_GEO_TX: if (div_done) state_d = tmcl_pkg::F_GEO_TY;
			tmcl_pkg::F_GEO_TY: if (div_done) state_d = tmcl_pkg::F_GEO_QX;
			tmcl_pkg::F_GEO_QX: if (div_done) state_d = tmcl_pkg::F_GEO_QY;
			tmcl_pkg::F_GEO_QY: if (div_done) state_d = pend_q ? tmcl_pkg::F_READ : tmcl_pkg::F_IDLE;
			tmcl_pkg::F_IDLE: begin
				if (pixel_valid)
					state_d = pixel.frame_start ? tmcl_pkg::F_GEO_TX : tmcl_pkg::F_READ;
			end
			tmcl_pkg::F_READ: state_d = tmcl_pkg::F_UPD;
			tmcl_pkg::F_UPD: begin
				if (upd_go) begin
					// frame complete: regrid before the next pixel
					if (col_end && (col_q + TC_W'(1)) >= tiles_x_q && row_end
						&& (row_q + TC_W'(1)) >= tiles_y_q)
						state_d = tmcl_pkg::F_GEO_TX;
					else
						state_d = tmcl_pkg::F_IDLE;
				end
			end
			default: state_d = tmcl_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			if (div_start)
				issued_q <= 1'b1;
			else if (div_done)
				issued_q <= 1'b0;
			if (pixel_valid && pixel_ready)
				pend_q <= pixel.frame_start;
			else if (upd_go)
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && pixel_ready)
			pix_q <= pixel;
		if (state_q == tmcl_pkg::F_READ)
			luma_q <= tmcl_pkg::PLUMA_W'(tmcl_pkg::LUMA_WR) * tmcl_pkg::PLUMA_W'(pix_q.red)
				+ tmcl_pkg::PLUMA_W'(tmcl_pkg::LUMA_WG) * tmcl_pkg::PLUMA_W'(pix_q.green)
				+ tmcl_pkg::PLUMA_W'(tmcl_pkg::LUMA_WB) * tmcl_pkg::PLUMA_W'(pix_q.blue);

		if (div_done) begin
			unique case (state_q)
				tmcl_pkg::F_GEO_TX: tiles_x_q <= tcount;
				tmcl_pkg::F_GEO_TY: tiles_y_q <= tcount;
				tmcl_pkg::F_GEO_QX: begin
					qx_q <= div_q;
					rx_q <= div_r;
				end
				tmcl_pkg::F_GEO_QY: begin
					// first tile of the frame
					qy_q       <= div_q;
					ry_q       <= div_r;
					py_q       <= '0;
					row_q      <= '0;
					top_q      <= '0;
					row_edge_q <= div_q;
					row_rem_q  <= div_r;
					px_q       <= '0;
					col_q      <= '0;
					left_q     <= '0;
					col_edge_q <= qx_q;
					col_rem_q  <= rx_q;
				end
				default: ;
			endcase
		end

		if (upd_go) begin
			if (!col_end) begin
				px_q <= px_q + W'(1);
			end else if ((col_q + TC_W'(1)) < tiles_x_q) begin
				col_q  <= col_q + TC_W'(1);
				left_q <= col_edge_q;
				px_q   <= px_q + W'(1);
				if (crem_sum >= {1'b0, W'(tiles_x_q)}) begin
					col_rem_q  <= W'(crem_sum - {1'b0, W'(tiles_x_q)});
					col_edge_q <= col_edge_q + qx_q + W'(1);
				end else begin
					col_rem_q  <= W'(crem_sum);
					col_edge_q <= col_edge_q + qx_q;
				end
			end else begin
				// start of next pixel row
				py_q       <= py_q + W'(1);
				px_q       <= '0;
				col_q      <= '0;
				left_q     <= '0;
				col_edge_q <= qx_q;
				col_rem_q  <= rx_q;
				if (row_end && (row_q + TC_W'(1)) < tiles_y_q) begin
					row_q <= row_q + TC_W'(1);
					top_q <= row_edge_q;
					if (rrem_sum >= {1'b0, W'(tiles_y_q)}) begin
						row_rem_q  <= W'(rrem_sum - {1'b0, W'(tiles_y_q)});
						row_edge_q <= row_edge_q + qy_q + W'(1);
					end else begin
						row_rem_q  <= W'(rrem_sum);
						row_edge_q <= row_edge_q + qy_q;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> src/tmcl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcl_back
// rounded mean of four sums per tile, four restoring divider lanes
// ----------------------------------------------------------------------------
module tmcl_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tmcl_pkg::tile_rec_t    rec,
	input  wire tmcl_pkg::queue_stat_t  qstat,
	output      logic                   pop,
	output      logic                   tile_valid,
	input  wire logic                   tile_ready,
	output      tmcl_pkg::tile_t        tile
);

	localparam int NW  = tmcl_pkg::LUMA_W + 1;
	localparam int DVW = tmcl_pkg::CNT_W + 8;
	localparam int MW  = tmcl_pkg::MEAN_W;
	localparam int BW  = $clog2(MW);

	tmcl_pkg::back_state_t state_q, state_d;

	tmcl_pkg::tile_rec_t   rec_q;
	logic [tmcl_pkg::CNT_W-1:0] cnt_q;
	logic [NW-1:0]  rem_q [4];
	logic [DVW-1:0] dvs_q [4];
	logic [MW-1:0]  quo_q [4];
	logic [BW-1:0]  bit_q;
	logic           load_out;

	assign pop      = state_q == tmcl_pkg::B_IDLE && !qstat.empty;
	assign load_out = state_q == tmcl_pkg::B_DONE && (!tile_valid || tile_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tmcl_pkg::B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmcl_pkg::B_IDLE: if (!qstat.empty) state_d = tmcl_pkg::B_MUL;
			tmcl_pkg::B_MUL:  state_d = tmcl_pkg::B_PREP;
			tmcl_pkg::B_PREP: state_d = tmcl_pkg::B_DIV;
			tmcl_pkg::B_DIV:  if (bit_q == '0) state_d = tmcl_pkg::B_DONE;
			tmcl_pkg::B_DONE: if (load_out) state_d = tmcl_pkg::B_IDLE;
			default:          state_d = tmcl_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= rec;
		if (state_q == tmcl_pkg::B_MUL)
			cnt_q <= rec_q.tile_w * rec_q.tile_h;
		if (state_q == tmcl_pkg::B_PREP) begin
			// half the divisor added for round to nearest
			rem_q[0] <= (NW'(rec_q.sum_red) << 8) + NW'(cnt_q >> 1);
			rem_q[1] <= (NW'(rec_q.sum_green) << 8) + NW'(cnt_q >> 1);
			rem_q[2] <= (NW'(rec_q.sum_blue) << 8) + NW'(cnt_q >> 1);
			rem_q[3] <= NW'(rec_q.sum_luma) + (NW'(cnt_q) << 7);
			dvs_q[0] <= DVW'(cnt_q);
			dvs_q[1] <= DVW'(cnt_q);
			dvs_q[2] <= DVW'(cnt_q);
			dvs_q[3] <= DVW'(cnt_q) << 8;
			bit_q    <= BW'(MW - 1);
			for (int i = 0; i < 4; i++)
				quo_q[i] <= '0;
		end
		if (state_q == tmcl_pkg::B_DIV) begin
			// quotient fits in 16 bits, so rem < divisor << 16 from the start
			for (int i = 0; i < 4; i++) begin
				if (rem_q[i] >= (NW'(dvs_q[i]) << bit_q)) begin
					rem_q[i]        <= rem_q[i] - (NW'(dvs_q[i]) << bit_q);
					quo_q[i][bit_q] <= 1'b1;
				end
			end
			bit_q <= bit_q - BW'(1);
		end
		if (load_out) begin
			tile.tile_row   <= rec_q.tile_row;
			tile.tile_col   <= rec_q.tile_col;
			tile.last_tile  <= rec_q.last_tile;
			tile.mean_red   <= quo_q[0];
			tile.mean_green <= quo_q[1];
			tile.mean_blue  <= quo_q[2];
			tile.mean_luma  <= quo_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tile_valid <= 1'b0;
		else if (load_out)
			tile_valid <= 1'b1;
		else if (tile_ready)
			tile_valid <= 1'b0;
	end

endmodule
`default_nettype wire

>>> src/tile_mean_color_luma_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_mean_color_luma_core
// block average downsampler: per-tile rounded means of rgb and luma in q8.8
// ----------------------------------------------------------------------------
// a pixel passes the front as accept, sum ram read, then add and write
// a frame_start pixel and the end of every frame add grid setup:
// four divisions through the shared 13-bit serial divider
// after its last pixel is summed, a tile word goes through pop, multiply, setup,
// 16 divide steps and the output register; back pops a new tile only after loading the last
// after reset the grid is built from the reset registers; no ram clear
// ----------------------------------------------------------------------------
module tile_mean_color_luma_core #(
	parameter int MAX_TILES  = tmcl_pkg::DEF_MAX_TILES,
	parameter int MAX_WIDTH  = tmcl_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tmcl_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [tmcl_pkg::CFG_W-1:0]    cfg_data,
	// pixel words in raster order
	input  wire logic                          pixel_valid,
	output      logic                          pixel_ready,
	input  wire tmcl_pkg::pixel_t              pixel,
	// finished tile words
	output      logic                          tile_valid,
	input  wire logic                          tile_ready,
	output      tmcl_pkg::tile_t               tile
);

	tmcl_pkg::cfg_t        cfg_q;
	tmcl_pkg::tile_rec_t   push_rec, pop_rec;
	tmcl_pkg::queue_stat_t qstat;
	logic                  push, pop, cfg_ok;

	// registers are held off while the grid is being set up, since the
	// setup reads them over many cycles
	assign cfg_ready = cfg_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= tmcl_pkg::CFG_W'(1024);
			cfg_q.image_height <= tmcl_pkg::CFG_W'(1024);
			cfg_q.tile_width   <= tmcl_pkg::CFG_W'(8);
			cfg_q.tile_height  <= tmcl_pkg::CFG_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (tmcl_pkg::cfg_reg_t'(cfg_index))
				tmcl_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				tmcl_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				tmcl_pkg::REG_TILE_WIDTH:   cfg_q.tile_width   <= cfg_data;
				tmcl_pkg::REG_TILE_HEIGHT:  cfg_q.tile_height  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: grid, counters, column sums
	tmcl_front #(
		.MAX_TILES  (MAX_TILES),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cfg_ok      (cfg_ok),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.push        (push),
		.rec         (push_rec),
		.qstat       (qstat)
	);

	// finished tiles wait here while the back divides
	tmcl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rec_in  (push_rec),
		.pop     (pop),
		.rec_out (pop_rec),
		.stat    (qstat)
	);

	// back: means and output register
	tmcl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec        (pop_rec),
		.qstat      (qstat),
		.pop        (pop),
		.tile_valid (tile_valid),
		.tile_ready (tile_ready),
		.tile       (tile)
	);

endmodule
`default_nettype wire
